// ===== rtl/core/cws_pkg.sv =====
// Shared types, constants and microcode ROM for the cosine wave shaper.
package cws_pkg;

   // Field and state widths.
   localparam int ValW   = 16;
   localparam int KnobW  = 15;
   localparam int AmtW   = 18;
   localparam int CvW    = 14;
   localparam int StepW  = 4;
   localparam int IterW  = 4;

   // Arithmetic constants of the amount and phase chain.
   localparam logic [CvW-1:0]   CV_FULL   = 14'd10240;
   localparam logic [AmtW-1:0]  AMT_MAX   = '1;
   localparam logic [19:0]      SCALE004  = 20'd671089;
   localparam logic [18:0]      RAD2TURN  = 19'd333772;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

   // Program locations that the sequencer and its checks refer to.
   localparam logic [StepW-1:0] STEP_LATCH  = 4'd0;
   localparam logic [StepW-1:0] STEP_CORDIC = 4'd9;
   localparam logic [StepW-1:0] STEP_LAST   = 4'd10;
   localparam logic [IterW-1:0] ITER_LAST   = 4'd15;

   // Datapath operations, one per control word.
   typedef enum logic [3:0] {
      OP_LATCH,
      OP_KNOB,
      OP_SCALE,
      OP_SQUARE,
      OP_GAIN,
      OP_SMOOTH,
      OP_MAG,
      OP_TURN,
      OP_FOLD,
      OP_CORDIC,
      OP_OUTPUT
   } op_type;

   // Conditions under which a step completes.
   typedef enum logic [1:0] {
      COND_NEXT,
      COND_WAIT_IN,
      COND_LOOP,
      COND_WAIT_OUT
   } cond_type;

   typedef struct packed {
      op_type               op;
      cond_type             cond;
      logic                 jump;
      logic [StepW-1:0]     target;
   } uop_type;

   // Control handed from the sequencer to the datapath.
   typedef struct packed {
      logic                 en;
      op_type               op;
      logic [IterW-1:0]     iter;
   } ctrl_type;

   // Arctangent of 2^-i in Q32 turns.
   function automatic logic [29:0] atan_turn(input logic [IterW-1:0] i);
      logic [29:0] v;
      case (i)
         4'd0:    v = 30'h20000000;
         4'd1:    v = 30'h12E4051E;
         4'd2:    v = 30'h09FB385B;
         4'd3:    v = 30'h051111D4;
         4'd4:    v = 30'h028B0D43;
         4'd5:    v = 30'h0145D7E1;
         4'd6:    v = 30'h00A2F61E;
         4'd7:    v = 30'h00517C55;
         4'd8:    v = 30'h0028BE53;
         4'd9:    v = 30'h00145F2F;
         4'd10:   v = 30'h000A2F98;
         4'd11:   v = 30'h000517CC;
         4'd12:   v = 30'h00028BE6;
         4'd13:   v = 30'h000145F3;
         4'd14:   v = 30'h0000A2FA;
         4'd15:   v = 30'h0000517D;
         default: v = '0;
      endcase
      return v;
   endfunction

   // The microprogram: one control word per step.
   function automatic uop_type uop_rom(input logic [StepW-1:0] step);
      uop_type u;
      u = '{op: OP_LATCH, cond: COND_WAIT_IN, jump: 1'b0, target: STEP_LATCH};
      case (step)
         4'd0:    u = '{op: OP_LATCH,  cond: COND_WAIT_IN,  jump: 1'b0, target: STEP_LATCH};
         4'd1:    u = '{op: OP_KNOB,   cond: COND_NEXT,     jump: 1'b0, target: STEP_LATCH};
         4'd2:    u = '{op: OP_SCALE,  cond: COND_NEXT,     jump: 1'b0, target: STEP_LATCH};
         4'd3:    u = '{op: OP_SQUARE, cond: COND_NEXT,     jump: 1'b0, target: STEP_LATCH};
         4'd4:    u = '{op: OP_GAIN,   cond: COND_NEXT,     jump: 1'b0, target: STEP_LATCH};
         4'd5:    u = '{op: OP_SMOOTH, cond: COND_NEXT,     jump: 1'b0, target: STEP_LATCH};
         4'd6:    u = '{op: OP_MAG,    cond: COND_NEXT,     jump: 1'b0, target: STEP_LATCH};
         4'd7:    u = '{op: OP_TURN,   cond: COND_NEXT,     jump: 1'b0, target: STEP_LATCH};
         4'd8:    u = '{op: OP_FOLD,   cond: COND_NEXT,     jump: 1'b0, target: STEP_LATCH};
         4'd9:    u = '{op: OP_CORDIC, cond: COND_LOOP,     jump: 1'b0, target: STEP_CORDIC};
         4'd10:   u = '{op: OP_OUTPUT, cond: COND_WAIT_OUT, jump: 1'b1, target: STEP_LATCH};
         default: u = '{op: OP_LATCH,  cond: COND_WAIT_IN,  jump: 1'b1, target: STEP_LATCH};
      endcase
      return u;
   endfunction

endpackage

// ===== rtl/core/cosine_wave_shaper_core.sv =====
// Top level of the cosine wave shaper: sequencer plus datapath.
//
//   Channel   Direction  Beat contents
//   req_      in         tdata: signal_in, amount_cv; tuser: cv_connected
//   rsp_      out        tdata: signal_out
//   csr_      in         wr_data: amount_knob (Q3.12), written when wr_en is high
//
// One sample runs from acceptance to result through one input step, eight
// amount and phase steps, sixteen CORDIC rotations on the single shared rotator,
// and one output step. The next beat is accepted once the result is in the
// output register, even while that beat waits on rsp_tready.
// Reset clears the knob, the smoothed amount, the sequencer and the output valid.
// A stalled output holds the sequencer at its output step only while the
// output register is still full.
module cosine_wave_shaper_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [2*cws_pkg::ValW-1:0] req_tdata,   // [15:0] signal_in, [31:16] amount_cv
   input  logic                       req_tuser,   // [0] cv_connected
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [cws_pkg::ValW-1:0]   rsp_tdata,   // [15:0] signal_out
   input  logic                       csr_wr_en,
   input  logic [cws_pkg::KnobW-1:0]  csr_wr_data
);
   import cws_pkg::*;

   ctrl_type ctrl;
   logic     out_free;

   // Program sequencer.
   cws_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_free   (out_free),
      .req_tready (req_tready),
      .ctrl       (ctrl)
   );

   // Arithmetic datapath and output register.
   cws_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .out_free    (out_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== rtl/core/cws_seq.sv =====
// Microcode sequencer: step counter, control ROM and CORDIC iteration counter.
module cws_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               out_free,
   output logic               req_tready,
   output cws_pkg::ctrl_type  ctrl
);
   import cws_pkg::*;

   logic [StepW-1:0] step_ff, step_in;
   logic [IterW-1:0] iter_ff, iter_in;
   uop_type          uop;
   logic             advance;
   logic             iter_last;

   // Fetch the control word of the current step.
   assign uop       = uop_rom(step_ff);
   assign iter_last = (iter_ff == ITER_LAST);

   // Decide whether the step completes this cycle and where it goes.
   always_comb begin
      case (uop.cond)
         COND_NEXT:     advance = 1'b1;
         COND_WAIT_IN:  advance = req_tvalid;
         COND_LOOP:     advance = 1'b1;
         COND_WAIT_OUT: advance = out_free;
         default:       advance = 1'b0;
      endcase

      step_in = step_ff;
      if (advance) begin
         if (uop.cond == COND_LOOP && !iter_last) begin
            step_in = uop.target;
         end else if (uop.jump) begin
            step_in = uop.target;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end

      // The iteration count runs only inside the rotation loop.
      if (advance && uop.op == OP_CORDIC) begin
         iter_in = iter_ff + 1'b1;
      end else begin
         iter_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_LATCH;
         iter_ff <= '0;
      end else begin
         step_ff <= step_in;
         iter_ff <= iter_in;
      end
   end

   assign req_tready = (uop.cond == COND_WAIT_IN);
   assign ctrl.en    = advance;
   assign ctrl.op    = uop.op;
   assign ctrl.iter  = iter_ff;

   // The iteration counter is idle whenever a new beat can be taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (iter_ff == '0))
      else $error("iteration count left over at input step");

   // The program counter never leaves the program.
   assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_LAST)
      else $error("step counter outside the program");

   // The rotation loop repeats its own step until the last iteration.
   assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_CORDIC && !iter_last) |=> (step_ff == STEP_CORDIC))
      else $error("rotation loop left early");

endmodule

// ===== rtl/core/cws_datapath.sv =====
// Datapath of the wave shaper: amount chain, phase, CORDIC rotator and output register.
module cws_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  cws_pkg::ctrl_type          ctrl,
   input  logic [2*cws_pkg::ValW-1:0] req_tdata,
   input  logic                       req_tuser,
   input  logic                       csr_wr_en,
   input  logic [cws_pkg::KnobW-1:0]  csr_wr_data,
   output logic                       out_free,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [cws_pkg::ValW-1:0]   rsp_tdata
);
   import cws_pkg::*;

   // Working registers.
   logic signed [ValW-1:0] s_ff, s_in;
   logic signed [ValW-1:0] cv_ff, cv_in;
   logic                   conn_ff, conn_in;
   logic [KnobW-1:0]       knob_ff;
   logic [28:0]            a_ff, a_in;
   logic [16:0]            x_ff, x_in;
   logic [33:0]            sq_ff, sq_in;
   logic [AmtW-1:0]        tgt_ff, tgt_in;
   logic [AmtW-1:0]        amt_ff, amt_in;
   logic [33:0]            mag_ff, mag_in;
   logic [31:0]            turn_ff, turn_in;
   logic signed [32:0]     cx_ff, cx_in;
   logic signed [32:0]     cy_ff, cy_in;
   logic signed [33:0]     cz_ff, cz_in;
   logic                   neg_ff, neg_in;
   logic [ValW-1:0]        out_ff, out_in;
   logic                   out_valid_ff, out_valid_in;

   // Intermediate values.
   logic [CvW-1:0]         cv_clamp;
   logic [49:0]            scale_sum;
   logic [36:0]            gain_sum;
   logic [19:0]            gain_q;
   logic [18:0]            smooth_sum;
   logic [ValW-1:0]        s_abs;
   logic [52:0]            turn_prod;
   logic signed [33:0]     zs;
   logic signed [32:0]     dx, dy;
   logic signed [33:0]     atan_s;
   logic signed [33:0]     xf;
   logic signed [33:0]     cr;
   logic signed [17:0]     diff;
   logic                   do_out;

   // Control voltage: 5 V when unplugged, otherwise clamped to 0..5 V.
   always_comb begin
      if (!conn_ff) begin
         cv_clamp = CV_FULL;
      end else if (cv_ff[ValW-1]) begin
         cv_clamp = '0;
      end else if (cv_ff > $signed({2'b00, CV_FULL})) begin
         cv_clamp = CV_FULL;
      end else begin
         cv_clamp = cv_ff[CvW-1:0];
      end
   end

   // Amount chain arithmetic, one product or wide add per step.
   assign scale_sum  = 50'(a_ff) * 50'(SCALE004) + 50'h40000000;
   assign gain_sum   = (37'(sq_ff) << 2) + 37'(sq_ff) + 37'h10000;
   assign gain_q     = gain_sum[36:17];
   assign smooth_sum = 19'(tgt_ff) + 19'(amt_ff) + 19'd1;
   assign s_abs      = s_ff[ValW-1] ? (~s_ff + 16'd1) : s_ff;
   assign turn_prod  = 53'(mag_ff) * 53'(RAD2TURN);

   // Phase folding and rotation terms.
   assign zs     = $signed({{2{turn_ff[31]}}, turn_ff});
   assign dx     = cy_ff >>> ctrl.iter;
   assign dy     = cx_ff >>> ctrl.iter;
   assign atan_s = $signed({4'b0000, atan_turn(ctrl.iter)});

   // Cosine rounded to Q11 and subtracted from the signal.
   assign xf   = neg_ff ? -$signed({cx_ff[32], cx_ff}) : $signed({cx_ff[32], cx_ff});
   assign cr   = (xf + 34'sd262144) >>> 19;
   assign diff = $signed({{2{s_ff[ValW-1]}}, s_ff}) - cr[17:0];

   assign out_free = !out_valid_ff || rsp_tready;
   assign do_out   = ctrl.en && (ctrl.op == OP_OUTPUT);

   // Next-state of the working registers, selected by the control word.
   always_comb begin
      s_in    = s_ff;
      cv_in   = cv_ff;
      conn_in = conn_ff;
      a_in    = a_ff;
      x_in    = x_ff;
      sq_in   = sq_ff;
      tgt_in  = tgt_ff;
      amt_in  = amt_ff;
      mag_in  = mag_ff;
      turn_in = turn_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cz_in   = cz_ff;
      neg_in  = neg_ff;
      out_in  = out_ff;
      if (ctrl.en) begin
         case (ctrl.op)
            OP_LATCH: begin
               s_in    = req_tdata[ValW-1:0];
               cv_in   = req_tdata[2*ValW-1:ValW];
               conn_in = req_tuser;
            end
            OP_KNOB:   a_in   = 29'(cv_clamp) * 29'(knob_ff);
            OP_SCALE:  x_in   = scale_sum[47:31];
            OP_SQUARE: sq_in  = 34'(x_ff) * 34'(x_ff);
            OP_GAIN:   tgt_in = (|gain_q[19:18]) ? AMT_MAX : gain_q[AmtW-1:0];
            OP_SMOOTH: amt_in = smooth_sum[18:1];
            OP_MAG:    mag_in = 34'(s_abs) * 34'(amt_ff);
            OP_TURN:   turn_in = turn_prod[47:16];
            OP_FOLD: begin
               cx_in  = CORDIC_GAIN;
               cy_in  = '0;
               if (zs > 34'sh40000000) begin
                  cz_in  = 34'sh80000000 - zs;
                  neg_in = 1'b1;
               end else if (zs < -34'sh40000000) begin
                  cz_in  = -34'sh80000000 - zs;
                  neg_in = 1'b1;
               end else begin
                  cz_in  = zs;
                  neg_in = 1'b0;
               end
            end
            OP_CORDIC: begin
               if (!cz_ff[33]) begin
                  cx_in = cx_ff - dx;
                  cy_in = cy_ff + dy;
                  cz_in = cz_ff - atan_s;
               end else begin
                  cx_in = cx_ff + dx;
                  cy_in = cy_ff - dy;
                  cz_in = cz_ff + atan_s;
               end
            end
            OP_OUTPUT: begin
               if (diff > 18'sd32767) begin
                  out_in = 16'h7FFF;
               end else if (diff < -18'sd32768) begin
                  out_in = 16'h8000;
               end else begin
                  out_in = diff[ValW-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   // Output beat valid: set on a new result, cleared when taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (do_out) begin
         out_valid_in = 1'b1;
      end
   end

   // Control state and smoothed amount; knob written from the CSR port.
   always_ff @(posedge clock) begin
      if (reset) begin
         knob_ff      <= '0;
         amt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            knob_ff <= csr_wr_data;
         end
         amt_ff       <= amt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      cv_ff   <= cv_in;
      conn_ff <= conn_in;
      a_ff    <= a_in;
      x_ff    <= x_in;
      sq_ff   <= sq_in;
      tgt_ff  <= tgt_in;
      mag_ff  <= mag_in;
      turn_ff <= turn_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      neg_ff  <= neg_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   // A result is only written into a free output slot.
   assert property (@(posedge clock) disable iff (reset)
      do_out |-> out_free)
      else $error("result written over a pending beat");

   // The folded phase stays within a quarter turn.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.en && ctrl.op == OP_FOLD) |=>
         (cz_ff <= 34'sh40000000 && cz_ff >= -34'sh40000000))
      else $error("folded phase out of range");

   // The smoothed amount only changes in the smoothing step.
   assert property (@(posedge clock) disable iff (reset)
      !$past(ctrl.en && ctrl.op == OP_SMOOTH) && !$past(reset) |-> $stable(amt_ff))
      else $error("smoothed amount changed outside its step");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the cosine wave shaper core with a built-in predictor.
module testbench;
   import cws_pkg::*;

   // Arithmetic constants of the amount and phase chain, at 64-bit precision.
   localparam longint CvFull     = 10240;
   localparam longint AmtMax     = 262143;
   localparam longint Scale004   = 671089;
   localparam longint Rad2Turn   = 333772;
   localparam longint CordicGain = 652032874;
   localparam longint HalfTurn   = 64'sd2147483648;
   localparam longint QuarterTurn = 64'sd1073741824;
   localparam longint FullTurn   = 64'sd4294967296;
   localparam int     Rotations  = 16;
   localparam int     LongHold   = 400;

   // Arctangent of 2^-i in Q32 turns.
   localparam longint AtanTurns [Rotations] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
   };

   typedef struct packed {
      logic               cv_connected;
      logic signed [15:0] amount_cv;
      logic signed [15:0] signal_in;
   } sample_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [2*ValW-1:0]    req_tdata = '0;   // [15:0] signal_in, [31:16] amount_cv
   logic                 req_tuser = 1'b0; // [0] cv_connected
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [ValW-1:0]      rsp_tdata;        // [15:0] signal_out
   logic                 csr_wr_en = 1'b0;
   logic [KnobW-1:0]     csr_wr_data = '0;

   sample_type           sample_queue [$];
   logic signed [15:0]   signal_out_q [$];
   longint               knob_model = 0;
   longint               smooth_amt = 0;
   int                   fail_count = 0;

   // Idling controls, set per phase by the sequence and read by driver and receiver.
   bit                   sender_gaps_on = 1'b1;
   logic [31:0]          stall_pattern = '1;
   int                   hold_requests = 0;

   cosine_wave_shaper_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Expected signal_out of one sample; advances the smoothed amount.
   function automatic logic signed [15:0] shape_sample(sample_type smp);
      longint sig, cv, prod, scaled, target, amt, mag, zph, xc, yc, dx, dy, cosv, res;
      bit     flip;
      int     i;
      sig = smp.signal_in;
      if (smp.cv_connected) begin
         cv = smp.amount_cv;
         if (cv < 0) cv = 0;
         else if (cv > CvFull) cv = CvFull;
      end else begin
         cv = CvFull;
      end
      prod   = cv * knob_model;
      scaled = (prod * Scale004 + 64'sd1073741824) >>> 31;
      target = (scaled * scaled * 5 + 64'sd65536) >>> 17;
      if (target > AmtMax) target = AmtMax;
      amt = (target + smooth_amt + 1) >>> 1;
      smooth_amt = amt;

      // Phase in Q0.32 turns; cosine is even so the magnitude is enough.
      mag = (sig < 0 ? -sig : sig) * amt;
      zph = ((mag * Rad2Turn) >>> 16) & 64'hFFFF_FFFF;
      if (zph >= HalfTurn) zph = zph - FullTurn;
      flip = 1'b0;
      if (zph > QuarterTurn) begin
         zph = HalfTurn - zph;
         flip = 1'b1;
      end else if (zph < -QuarterTurn) begin
         zph = -HalfTurn - zph;
         flip = 1'b1;
      end

      // Rotation-mode CORDIC with the gain folded into the start vector.
      xc = CordicGain;
      yc = 0;
      for (i = 0; i < Rotations; i++) begin
         dx = yc >>> i;
         dy = xc >>> i;
         if (zph >= 0) begin
            xc = xc - dx;
            yc = yc + dy;
            zph = zph - AtanTurns[i];
         end else begin
            xc = xc + dx;
            yc = yc - dy;
            zph = zph + AtanTurns[i];
         end
      end
      if (flip) xc = -xc;
      cosv = (xc + 64'sd262144) >>> 19;
      res = sig - cosv;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return 16'(res);
   endfunction

   // Random sample with a bias toward extremes and the clamp edges.
   function automatic sample_type random_sample();
      sample_type smp;
      int         pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) smp.signal_in = 16'($urandom);
      else if (pick < 7) smp.signal_in = 16'(int'($urandom_range(0, 4096)) - 2048);
      else if (pick == 7) begin
         case ($urandom_range(0, 2))
            0: smp.signal_in = 16'sh7FFF;
            1: smp.signal_in = 16'sh8000;
            default: smp.signal_in = 16'sh0000;
         endcase
      end else begin
         smp.signal_in = 16'(int'($urandom_range(28000, 32767)));
         if ($urandom_range(0, 1)) smp.signal_in = -smp.signal_in;
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) smp.amount_cv = 16'($urandom_range(0, 10240));
      else if (pick < 7) smp.amount_cv = 16'($urandom);
      else if (pick == 7) begin
         case ($urandom_range(0, 3))
            0: smp.amount_cv = 16'sh0000;
            1: smp.amount_cv = 16'sd10240;
            2: smp.amount_cv = 16'sh8000;
            default: smp.amount_cv = 16'sh7FFF;
         endcase
      end else if (pick == 8) begin
         smp.amount_cv = 16'(int'($urandom_range(10230, 10250)));
      end else begin
         smp.amount_cv = 16'(int'($urandom_range(0, 20)) - 10);
      end
      smp.cv_connected = ($urandom_range(0, 3) != 0);
      return smp;
   endfunction

   task automatic add_sample(int sig, int cv, bit conn);
      sample_queue.push_back('{cv_connected: conn, amount_cv: 16'(cv), signal_in: 16'(sig)});
   endtask

   // Waits until the block is idle with nothing outstanding.
   task automatic wait_drain();
      while (sample_queue.size() != 0 || signal_out_q.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_knob(longint value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= KnobW'(value);
      knob_model   = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Input driver: bursts of beats from the sample queue with random gaps.
   sample_type offer;
   bit         offer_valid = 1'b0;
   int         burst_left = 0;
   int         gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         offer       = '0;
         offer_valid = 1'b0;
         burst_left  = 0;
         gap_left    = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            signal_out_q.push_back(shape_sample(sample_queue.pop_front()));
            offer_valid = 1'b0;
         end
         if (!offer_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (sample_queue.size() > 0) begin
               offer       = sample_queue[0];
               offer_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  gap_left = (sender_gaps_on && $urandom_range(0, 3) != 0) ?
                             $urandom_range(1, 30) : 0;
               end
            end
         end
      end
      req_tvalid <= offer_valid;
      req_tdata  <= {offer.amount_cv, offer.signal_in};
      req_tuser  <= offer.cv_connected;
   end

   // Result receiver: stalls from a rotating pattern, plus long holds on request.
   int       hold_served = 0;
   int       hold_left = 0;
   bit [4:0] rx_slot = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = LongHold;
         rsp_tready <= 1'b0;
      end else begin
         rx_slot = rx_slot + 1'b1;
         rsp_tready <= stall_pattern[rx_slot];
      end
   end

   // Result monitor: each accepted beat is checked against the oldest expectation.
   always @(posedge clock) begin
      logic signed [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (signal_out_q.size() == 0) begin
            $error("signal_out beat with no expected value: expected none, actual %0d",
                   $signed(rsp_tdata));
            fail_count++;
         end else begin
            want = signal_out_q.pop_front();
            if (rsp_tdata !== want) begin
               $error("signal_out mismatch: expected %0d, actual %0d", want,
                      $signed(rsp_tdata));
               fail_count++;
            end
         end
      end
   end

   // Stimulus sequence: directed samples, then random phases over several knob settings.
   initial begin
      int     ph;
      longint knob_value;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Knob at its reset value: the amount stays at zero and cos stays near one.
      add_sample(0, 0, 0);
      add_sample(32767, 0, 1);
      add_sample(-32768, 0, 1);
      wait_drain();

      // Full-scale knob: clamp edges, disconnected jack and output saturation.
      write_knob(20480);
      add_sample(0, 0, 0);
      add_sample(1000, -32768, 1);
      add_sample(1000, 32767, 1);
      add_sample(1000, 10240, 1);
      add_sample(1000, 10241, 1);
      add_sample(1000, -1, 1);
      add_sample(1000, 0, 1);
      add_sample(32767, 5000, 0);
      add_sample(-32768, 5000, 0);
      add_sample(-1, 20000, 1);
      add_sample(1, 7000, 1);
      add_sample(16384, 10240, 1);
      add_sample(-16384, 2048, 0);
      add_sample(32767, -32768, 0);
      add_sample(-32768, 32767, 1);
      wait_drain();

      // Knob beyond 5.0, so the target saturates.
      write_knob(32767);
      add_sample(32767, 10240, 1);
      add_sample(-32768, 32767, 0);
      add_sample(12345, 0, 0);
      add_sample(30000, 9000, 1);
      wait_drain();

      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: knob_value = 1;
            1: knob_value = 4096;
            2: knob_value = $urandom_range(0, 20480);
            3: knob_value = $urandom_range(0, 20480);
            4: knob_value = 20480;
            5: knob_value = $urandom_range(0, 32767);
            6: knob_value = 12000;
            default: knob_value = 0;
         endcase
         sender_gaps_on = (ph != 2 && ph != 6);
         stall_pattern  = (ph == 1 || ph == 6) ? '1 : ($urandom | 32'h1);
         write_knob(knob_value);
         // One phase starves the output for a long stretch so the input backs up.
         if (ph == 3) hold_requests++;
         repeat (128) sample_queue.push_back(random_sample());
         wait_drain();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #1000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
